[rtl/core/deq_pkg.sv]
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types, widths and the ring index helper of the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = CNT_W + 1;
    localparam int DATA_W  = 32;
    localparam int OP_W    = 3;
    localparam int COUNT_W = 5;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 72;

    localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;

    typedef enum logic [OP_W-1:0] {
        OP_QUERY      = 3'd0,
        OP_INS_FRONT  = 3'd1,
        OP_INS_REAR   = 3'd2,
        OP_DEL_FRONT  = 3'd3,
        OP_DEL_REAR   = 3'd4
    } t_op;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    typedef struct packed {
        logic                     pad;
        logic                     rejected;
        logic                     empty_res;
        logic [COUNT_W-1:0]       count;
        logic signed [DATA_W-1:0] rear_value;
        logic signed [DATA_W-1:0] front_value;
    } t_result;

    // base + offset modulo DEPTH, with base < DEPTH and offset <= DEPTH
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] offset);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(offset);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

[rtl/core/double_ended_queue.sv]
// ----------------------------------------------------------------------------
// double_ended_queue
// Deque of signed 32-bit values kept in a ring buffer RAM.
// ----------------------------------------------------------------------------
// Each input beat carries an operation in tuser and a value in tdata; each
// beat yields one result beat with the front and rear values, the count and
// the empty and rejected flags. Front and rear are cached in registers, so a
// query, an insert, a rejected operation or a delete that empties the queue
// needs no RAM read. A delete that leaves entries behind fetches the new
// front or rear from the entry RAM (registered read data), holding off
// input in a read state meanwhile. A result register with a one-beat skid
// stage keeps input beats flowing while output waits, until the skid is full.
module double_ended_queue (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [deq_pkg::IN_TDATA_W-1:0]   i_s_tdata,   // value[31:0]
    input  logic [deq_pkg::OP_W-1:0]         i_s_tuser,   // opcode[2:0]
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // front_value[31:0], rear_value[63:32], count[68:64], empty_res[69],
    // rejected[70], zero pad[71]
    output logic [deq_pkg::OUT_TDATA_W-1:0]  o_m_tdata
);

    import deq_pkg::*;

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_head, n_head;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [DATA_W-1:0] r_front, n_front;
    logic [DATA_W-1:0] r_rear, n_rear;
    logic              r_fill_front, n_fill_front;
    logic              r_out_valid;
    t_result           r_out;
    logic              r_skid_valid;
    t_result           r_skid;

    logic              s_accept;
    logic              need_read;
    logic              rej;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [DATA_W-1:0] ram_rdata;
    logic              res_valid;
    t_result           res;
    logic              out_free;
    logic              full;
    logic              empty;

    assign full     = (r_count == CNT_W'(DEPTH));
    assign empty    = (r_count == '0);
    assign s_accept = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_valid || i_m_tready;

    deq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH),
        .ADDR_W(IDX_W)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(i_s_tdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // operation decode and pointer update
    always_comb begin
        n_head       = r_head;
        n_count      = r_count;
        n_front      = r_front;
        n_rear       = r_rear;
        n_fill_front = r_fill_front;
        rej          = 1'b0;
        need_read    = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = r_head;
        ram_raddr    = r_head;
        if (s_accept) begin
            case (t_op'(i_s_tuser))
                OP_INS_FRONT: begin
                    if (full) begin
                        rej = 1'b1;
                    end else begin
                        n_head    = (r_head == '0) ? IDX_W'(DEPTH - 1) : r_head - 1'b1;
                        ram_we    = 1'b1;
                        ram_waddr = n_head;
                        n_count   = r_count + 1'b1;
                        n_front   = i_s_tdata;
                        if (empty) begin
                            n_rear = i_s_tdata;
                        end
                    end
                end
                OP_INS_REAR: begin
                    if (full) begin
                        rej = 1'b1;
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = ring_add(r_head, r_count);
                        n_count   = r_count + 1'b1;
                        n_rear    = i_s_tdata;
                        if (empty) begin
                            n_front = i_s_tdata;
                        end
                    end
                end
                OP_DEL_FRONT: begin
                    if (empty) begin
                        rej = 1'b1;
                    end else begin
                        n_head       = ring_add(r_head, CNT_W'(1));
                        n_count      = r_count - 1'b1;
                        need_read    = (n_count != '0);
                        ram_raddr    = n_head;
                        n_fill_front = 1'b1;
                    end
                end
                OP_DEL_REAR: begin
                    if (empty) begin
                        rej = 1'b1;
                    end else begin
                        n_count      = r_count - 1'b1;
                        need_read    = (n_count != '0);
                        ram_raddr    = ring_add(r_head, n_count - 1'b1);
                        n_fill_front = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end else if (r_state == ST_READ) begin
            if (r_fill_front) begin
                n_front = ram_rdata;
            end else begin
                n_rear = ram_rdata;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_accept && need_read) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_s_tready      = 1'b0;
        ram_re          = 1'b0;
        res_valid       = 1'b0;
        res.pad         = 1'b0;
        res.rejected    = rej;
        res.empty_res   = (n_count == '0);
        res.count       = COUNT_W'(n_count);
        res.front_value = (n_count == '0) ? INT_MIN : n_front;
        res.rear_value  = (n_count == '0) ? INT_MIN : n_rear;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = !r_skid_valid;
                ram_re     = s_accept && need_read;
                res_valid  = s_accept && !need_read;
            end
            ST_READ: begin
                res_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_head       <= '0;
            r_count      <= '0;
            r_fill_front <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_count      <= n_count;
            r_fill_front <= n_fill_front;
            if (out_free) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= res_valid;
                end
            end else if (res_valid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_front <= n_front;
        r_rear  <= n_rear;
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (res_valid) begin
                r_out <= res;
            end
        end else if (res_valid) begin
            r_skid <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a beat while output register is empty");

    a_read_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> !r_skid_valid)
        else $error("read return has no free result slot");

    a_read_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |=> (r_state == ST_IDLE))
        else $error("read state held longer than one cycle");

    a_reject_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_out.rejected) |->
            (r_out.count == '0 || r_out.count == COUNT_W'(DEPTH)))
        else $error("rejected beat with neither empty nor full queue");

endmodule

[rtl/core/deq_ram.sv]
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
